FILE: rtl/core/dwmf_pkg.sv
package dwmf_pkg;

    localparam int SYMBOL_BITS   = 8;
    localparam int NUM_CELLS     = 256;
    localparam int CELL_IDX_BITS = 8;
    localparam int WS_BITS       = 9;

    localparam logic [WS_BITS-1:0] WS_RESET = 9'd4;

    // Update command broadcast along the cell row
    typedef struct packed {
        logic advance;
        logic clear;
    } dwmf_ctrl_t;

endpackage

FILE: rtl/core/dwmf_cell.sv
module dwmf_cell #(
    parameter int POSITION_BITS = 16,
    parameter int CELL_INDEX    = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dwmf_pkg::dwmf_ctrl_t                ctrl,
    input  logic [dwmf_pkg::SYMBOL_BITS-1:0]    symbol,
    input  logic [dwmf_pkg::CELL_IDX_BITS-1:0]  hit_index,
    input  logic                                any_hit,
    input  logic                                prev_valid,
    input  logic [dwmf_pkg::SYMBOL_BITS-1:0]    prev_symbol,
    input  logic [POSITION_BITS-1:0]            prev_pos,
    output logic                                valid,
    output logic [dwmf_pkg::SYMBOL_BITS-1:0]    symbol_q,
    output logic [POSITION_BITS-1:0]            pos_q,
    output logic                                hit
);
    import dwmf_pkg::*;

    logic                     valid_reg;
    logic [SYMBOL_BITS-1:0]   symbol_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     take;

    // Move-to-front: cells 0..hit (all on a miss) take their neighbour, the rest hold
    assign take = !any_hit || (hit_index >= CELL_IDX_BITS'(CELL_INDEX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.advance && take)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance && take)
        begin
            symbol_reg <= prev_symbol;
            pos_reg    <= prev_pos;
        end
    end

    assign hit      = valid_reg && (symbol_reg == symbol);
    assign valid    = valid_reg;
    assign symbol_q = symbol_reg;
    assign pos_q    = pos_reg;

endmodule

FILE: rtl/core/dwmf_chain.sv
module dwmf_chain #(
    parameter int POSITION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dwmf_pkg::dwmf_ctrl_t              ctrl,
    input  logic [dwmf_pkg::SYMBOL_BITS-1:0]  symbol,
    input  logic [POSITION_BITS-1:0]          here,
    output logic                              any_hit,
    output logic [POSITION_BITS-1:0]          hit_pos
);
    import dwmf_pkg::*;

    logic                     valid_w  [NUM_CELLS];
    logic [SYMBOL_BITS-1:0]   symbol_w [NUM_CELLS];
    logic [POSITION_BITS-1:0] pos_w    [NUM_CELLS];
    logic                     hit_w    [NUM_CELLS];
    logic [CELL_IDX_BITS-1:0] hit_index;

    // Valid symbols are unique in the row, so at most one cell hits and plain ORs suffice
    always_comb
    begin
        any_hit   = 1'b0;
        hit_index = '0;
        hit_pos   = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            any_hit   = any_hit | hit_w[i];
            hit_index = hit_index | (hit_w[i] ? CELL_IDX_BITS'(i) : '0);
            hit_pos   = hit_pos | (hit_w[i] ? pos_w[i] : '0);
        end
    end

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        logic                     prev_valid;
        logic [SYMBOL_BITS-1:0]   prev_symbol;
        logic [POSITION_BITS-1:0] prev_pos;

        if (g == 0)
        begin : g_head
            assign prev_valid  = 1'b1;
            assign prev_symbol = symbol;
            assign prev_pos    = here;
        end
        else
        begin : g_body
            assign prev_valid  = valid_w[g-1];
            assign prev_symbol = symbol_w[g-1];
            assign prev_pos    = pos_w[g-1];
        end

        dwmf_cell #(
            .POSITION_BITS (POSITION_BITS),
            .CELL_INDEX    (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .symbol      (symbol),
            .hit_index   (hit_index),
            .any_hit     (any_hit),
            .prev_valid  (prev_valid),
            .prev_symbol (prev_symbol),
            .prev_pos    (prev_pos),
            .valid       (valid_w[g]),
            .symbol_q    (symbol_w[g]),
            .pos_q       (pos_w[g]),
            .hit         (hit_w[g])
        );
    end

endmodule

FILE: rtl/core/distinct_window_marker_finder.sv
// Distinct-window marker finder.
// Input channel (in_valid/in_ready): one stream byte per transaction in symbol, with
// end_of_stream set on the last byte. Output channel (out_valid/out_ready): at most one
// transaction per stream, carrying position (1-based byte count, saturating) and found.
// found is set when the last window_size bytes are all distinct; bytes after the marker
// are consumed silently. A stream ending without a marker reports its length, found clear.
// window_size is loaded through cfg_write_en/cfg_write_data; the user must load it only
// between streams, which the block itself does not enforce. Throughput: one byte per
// cycle while in_ready is high. Each byte is searched against a 256-cell move-to-front
// row holding the last position of every byte value seen in the stream; the search, the
// run update and the row shift all complete in the accepting cycle. A result is
// registered and presented in the cycle after the byte that causes it is accepted.
// A stalled receiver holds the result in the output register; in_ready drops only while
// that register is full and out_ready is low. Reset: window_size returns to 4, the row
// is emptied and the stream state cleared; the row also empties at every end of stream.
module distinct_window_marker_finder #(
    parameter int POSITION_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [dwmf_pkg::WS_BITS-1:0]     cfg_write_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [dwmf_pkg::SYMBOL_BITS-1:0] symbol,
    input  logic                             end_of_stream,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [POSITION_BITS-1:0]         position,
    output logic                             found
);
    import dwmf_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam int CMP_BITS = (POSITION_BITS > WS_BITS) ? POSITION_BITS : WS_BITS;

    logic [WS_BITS-1:0]       window_size_reg;
    logic [POSITION_BITS-1:0] byte_count_reg, byte_count_next;
    logic [POSITION_BITS-1:0] window_start_reg, window_start_next;
    logic                     marker_done_reg, marker_done_next;
    logic                     out_valid_reg, out_valid_next;
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic                     found_reg, found_next;

    dwmf_ctrl_t               ctrl;
    logic                     in_fire;
    logic                     any_hit;
    logic [POSITION_BITS-1:0] hit_pos;
    logic [POSITION_BITS-1:0] count_inc;
    logic [POSITION_BITS-1:0] start_jump;
    logic [POSITION_BITS-1:0] start_cap;
    logic [POSITION_BITS-1:0] run;
    logic                     repeat_in_run;
    logic                     marker_hit;
    logic                     result_valid;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    dwmf_chain #(
        .POSITION_BITS (POSITION_BITS)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .symbol  (symbol),
        .here    (byte_count_reg),
        .any_hit (any_hit),
        .hit_pos (hit_pos)
    );

    always_comb
    begin
        count_inc     = (byte_count_reg == POS_MAX) ? POS_MAX : byte_count_reg + 1'b1;
        repeat_in_run = any_hit && (hit_pos >= window_start_reg);
        start_jump    = window_start_reg;
        if (repeat_in_run)
        begin
            start_jump = (hit_pos == POS_MAX) ? POS_MAX : hit_pos + 1'b1;
        end
        start_cap  = (start_jump > count_inc) ? count_inc : start_jump;
        run        = count_inc - start_cap;
        marker_hit = CMP_BITS'(run) >= CMP_BITS'(window_size_reg);
    end

    // Stream state update
    always_comb
    begin
        ctrl.advance      = 1'b0;
        ctrl.clear        = 1'b0;
        byte_count_next   = byte_count_reg;
        window_start_next = window_start_reg;
        marker_done_next  = marker_done_reg;
        result_valid      = 1'b0;
        found_next        = found_reg;
        position_next     = position_reg;

        if (in_fire)
        begin
            if (marker_done_reg)
            begin
                ctrl.clear = end_of_stream;
            end
            else
            begin
                ctrl.advance      = 1'b1;
                ctrl.clear        = end_of_stream;
                byte_count_next   = count_inc;
                window_start_next = start_cap;
                position_next     = count_inc;
                found_next        = marker_hit;
                result_valid      = marker_hit || end_of_stream;
                marker_done_next  = marker_hit;
            end
            if (ctrl.clear)
            begin
                byte_count_next   = '0;
                window_start_next = '0;
                marker_done_next  = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= WS_RESET;
            byte_count_reg   <= '0;
            window_start_reg <= '0;
            marker_done_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                window_size_reg <= cfg_write_data;
            end
            byte_count_reg   <= byte_count_next;
            window_start_reg <= window_start_next;
            marker_done_reg  <= marker_done_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Hold the result payload until a new one is produced
    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            position_reg <= position_next;
            found_reg    <= found_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign found     = found_reg;

    a_no_result_after_marker : assert property (
        @(posedge clk) disable iff (!rst_n)
        !(result_valid && marker_done_reg)
    ) else $error("result produced after marker already reported");

    a_start_within_count : assert property (
        @(posedge clk) disable iff (!rst_n)
        window_start_reg <= byte_count_reg
    ) else $error("window start passed byte count");

    a_stream_cleared : assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire && end_of_stream |=> byte_count_reg == '0 && !marker_done_reg
            && window_start_reg == '0
    ) else $error("stream state not cleared at end of stream");

    a_result_overwrite : assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> !out_valid_reg || out_ready
    ) else $error("pending result overwritten");

endmodule

FILE: test/distinct_window_marker_finder_tb.sv
`timescale 1ns / 1ps

module distinct_window_marker_finder_tb;

    import dwmf_pkg::*;

    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_TOP = '1;

    typedef struct packed {
        logic [POS_BITS-1:0] position;
        logic                found;
    } marker_result_t;

    typedef logic [SYMBOL_BITS-1:0] symbol_q_t [$];

    typedef enum int {
        MARKED,
        CLUSTERED,
        NOISE
    } stream_kind_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write_en;
    logic [WS_BITS-1:0]       cfg_write_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [SYMBOL_BITS-1:0]   symbol;
    logic                     end_of_stream;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [POS_BITS-1:0]      position;
    logic                     found;

    // Shadow of the block's stream state
    logic [POS_BITS-1:0]      seen_at [NUM_CELLS];
    bit                       seen_ok [NUM_CELLS];
    logic [POS_BITS-1:0]      run_start;
    logic [POS_BITS-1:0]      byte_count;
    bit                       marker_seen;
    logic [WS_BITS-1:0]       window_len;

    marker_result_t           pending_markers [$];
    marker_result_t           oldest;
    int                       errors = 0;
    int                       bytes_sent = 0;
    int                       rx_wait = 0;
    bit                       rx_taken = 1'b0;
    bit                       idle_on = 1'b1;

    distinct_window_marker_finder #(
        .POSITION_BITS(POS_BITS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .symbol         (symbol),
        .end_of_stream  (end_of_stream),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .position       (position),
        .found          (found)
    );

    always #5 clk = ~clk;

    function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_TOP) ? v : v + 1'b1;
    endfunction

    function automatic void clear_stream_state();
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            seen_ok[i] = 1'b0;
        end
        run_start   = '0;
        byte_count  = '0;
        marker_seen = 1'b0;
    endfunction

    function automatic void predict_marker(input logic [SYMBOL_BITS-1:0] s, input logic last);
        logic [POS_BITS-1:0] here;
        logic [POS_BITS-1:0] run;
        marker_result_t      r;
        if (marker_seen)
        begin
            if (last)
                clear_stream_state();
            return;
        end
        here = byte_count;
        if (seen_ok[s] && seen_at[s] >= run_start)
            run_start = pos_inc(seen_at[s]);
        seen_at[s] = here;
        seen_ok[s] = 1'b1;
        byte_count = pos_inc(byte_count);
        if (run_start > byte_count)
            run_start = byte_count;
        run = byte_count - run_start;
        if (run >= window_len)
        begin
            r.position = byte_count;
            r.found    = 1'b1;
            pending_markers = {pending_markers, r};
            if (last)
                clear_stream_state();
            else
                marker_seen = 1'b1;
        end
        else if (last)
        begin
            r.position = byte_count;
            r.found    = 1'b0;
            pending_markers = {pending_markers, r};
            clear_stream_state();
        end
    endfunction

    // Receiver: hold ready low for the drawn number of cycles after each transaction
    always @(negedge clk)
    begin
        int wait_now;
        wait_now = rx_wait;
        if (rx_taken)
            wait_now = idle_on ? $urandom_range(0, 4) : 0;
        if (wait_now > 0)
        begin
            out_ready <= 1'b0;
            rx_wait   <= wait_now - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            rx_wait   <= 0;
        end
    end

    always @(posedge clk)
    begin
        rx_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_markers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual position %0d found %0b",
                         $time, position, found);
                errors++;
            end
            else
            begin
                oldest = pending_markers.pop_front();
                if (position !== oldest.position)
                begin
                    $display("%0t: position mismatch, expected %0d actual %0d",
                             $time, oldest.position, position);
                    errors++;
                end
                if (found !== oldest.found)
                begin
                    $display("%0t: found mismatch, expected %0b actual %0b",
                             $time, oldest.found, found);
                    errors++;
                end
            end
        end
    end

    task automatic send_byte(input logic [SYMBOL_BITS-1:0] s, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        symbol        <= s;
        end_of_stream <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_marker(s, last);
        bytes_sent++;
    endtask

    task automatic send_bytes(input symbol_q_t data, input logic close);
        foreach (data[k])
        begin
            send_byte(data[k], close && (k == data.size() - 1));
        end
    endtask

    // Drop valid, drain the results and let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_markers.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(input logic [WS_BITS-1:0] v);
        settle();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        window_len = v;
    endtask

    task automatic test_default_window();
        // marker inside the stream, trailing bytes dropped until the end
        send_bytes('{8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'h55, 8'hAA}, 1'b1);
        // marker on the closing byte
        send_bytes('{8'h12, 8'h34, 8'h56, 8'h78}, 1'b1);
        // stream ends without a marker
        send_bytes('{8'h01, 8'h01, 8'h02, 8'h01}, 1'b1);
        send_bytes('{8'hFF}, 1'b1);
    endtask

    task automatic test_window_extremes();
        symbol_q_t seq;
        write_window(9'd1);
        send_bytes('{8'hAA}, 1'b1);
        send_bytes('{8'h3C, 8'hC3}, 1'b1);
        write_window(9'd256);
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            seq = {seq, i[7:0]};
        end
        send_bytes(seq, 1'b1);
        // one repeat in the middle pushes the marker out past the end
        seq[100] = 8'd37;
        send_bytes(seq, 1'b1);
    endtask

    task automatic test_window_out_of_range();
        symbol_q_t seq;
        write_window(9'd0);
        send_bytes('{8'h5A}, 1'b1);
        write_window(9'd511);
        for (int i = 0; i < NUM_CELLS + 4; i++)
        begin
            seq = {seq, i[7:0]};
        end
        send_bytes(seq, 1'b1);
    endtask

    task automatic test_midstream_config();
        write_window(9'd14);
        send_bytes('{8'h07, 8'h07, 8'h01, 8'h02, 8'h03}, 1'b0);
        write_window(9'd3);
        send_bytes('{8'h04, 8'h09, 8'hF0}, 1'b1);
    endtask

    task automatic test_position_saturation();
        write_window(9'd8);
        idle_on = 1'b0;
        repeat (65600)
            send_byte(8'($urandom_range(0, 3)), 1'b0);
        for (int i = 4; i < 12; i++)
        begin
            send_byte(i[7:0], 1'b0);
        end
        send_byte(8'h02, 1'b1);
        idle_on = 1'b1;
        // the next stream must start from a clean count
        send_bytes('{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07}, 1'b1);
    endtask

    task automatic send_random_stream(input stream_kind_t kind);
        logic [SYMBOL_BITS-1:0] perm [NUM_CELLS];
        symbol_q_t              seq;
        logic [SYMBOL_BITS-1:0] t;
        logic [SYMBOL_BITS-1:0] base;
        int                     i;
        int                     j;
        int                     n;
        int                     len;
        int                     alph;
        for (i = 0; i < NUM_CELLS; i++)
        begin
            perm[i] = i[7:0];
        end
        for (i = NUM_CELLS - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        n = (window_len > NUM_CELLS) ? NUM_CELLS : int'(window_len);
        case (kind)
            MARKED:
            begin
                len = $urandom_range(0, 12);
                repeat (len)
                    seq = {seq, perm[$urandom_range(0, n - 1)]};
                for (i = 0; i < n; i++)
                begin
                    seq = {seq, perm[i]};
                end
                len = $urandom_range(0, 12);
                repeat (len)
                    seq = {seq, 8'($urandom_range(0, 255))};
            end
            CLUSTERED:
            begin
                alph = n + $urandom_range(0, 2);
                if (alph > NUM_CELLS)
                    alph = NUM_CELLS;
                base = 8'($urandom_range(0, 255));
                len  = $urandom_range(1, n + 20);
                repeat (len)
                    seq = {seq, 8'(base + $urandom_range(0, alph - 1))};
            end
            default:
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                    seq = {seq, 8'($urandom_range(0, 255))};
            end
        endcase
        send_bytes(seq, 1'b1);
    endtask

    task automatic test_random_streams();
        int first;
        int pick;
        int streams;
        first = bytes_sent;
        while (bytes_sent - first < 1200)
        begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       write_window(9'd256);
                1:       write_window(9'($urandom_range(17, 255)));
                2, 3:    write_window(9'd14);
                4, 5:    write_window(9'd4);
                6:       write_window(9'd1);
                default: write_window(9'($urandom_range(1, 16)));
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            streams = (window_len > 32) ? 1 : $urandom_range(1, 4);
            repeat (streams)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    send_random_stream(MARKED);
                else if (pick < 9)
                    send_random_stream(CLUSTERED);
                else
                    send_random_stream(NOISE);
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        symbol         = '0;
        end_of_stream  = 1'b0;
        window_len     = WS_RESET;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            seen_at[i] = '0;
        end
        clear_stream_state();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_default_window();
        test_window_extremes();
        test_window_out_of_range();
        test_midstream_config();
        test_position_saturation();
        test_random_streams();

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/dwmf_pkg.sv
rtl/core/dwmf_cell.sv
rtl/core/dwmf_chain.sv
rtl/core/distinct_window_marker_finder.sv
test/distinct_window_marker_finder_tb.sv
